### rtl/assert_macros.svh
// Assertion macros, included by the top level of the handle table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### rtl/ght_pkg.sv
// Types and constants for the generational handle table.
package ght_pkg;
   localparam int SLOT_COUNT = 64;
   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = 7;
   localparam logic [6:0] MARKER = 7'h5d;
   localparam logic [15:0] GEN_LIMIT_NARROW = 16'h07ff;
   localparam logic [15:0] GEN_LIMIT_WIDE = 16'hffff;

   typedef enum logic [2:0] {
      ST_FREE = 3'd0, ST_ALLOC = 3'd1, ST_DELIV = 3'd2,
      ST_CONS = 3'd3, ST_EXP = 3'd4, ST_RET = 3'd5
   } slot_state_type;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0, OP_RESOLVE = 3'd1, OP_MARK = 3'd2, OP_CONSUME = 3'd3,
      OP_EXPIRE = 3'd4, OP_EXPIRE_USAGE = 3'd5, OP_RESET_ALL = 3'd6, OP_NONE = 3'd7
   } op_type;

   localparam logic [2:0] RS_OK = 3'd0;
   localparam logic [2:0] RS_UNKNOWN = 3'd1;
   localparam logic [2:0] RS_STALE = 3'd2;
   localparam logic [2:0] RS_CONSUMED = 3'd3;
   localparam logic [2:0] RS_FULL = 3'd4;

   localparam logic REG_FORMAT = 1'b0;
   localparam logic REG_TAG = 1'b1;

   typedef enum logic [2:0] {
      FSM_CLEAR, FSM_IDLE, FSM_READ, FSM_WRITE, FSM_DONE
   } fsm_type;

   // one slot record as kept in the slot RAM
   typedef struct packed {
      logic usage;
      logic [15:0] gen;
      slot_state_type st;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic [2:0] req_type;
      logic [63:0] token;
      logic usage_class;
      logic [31:0] payload_ref_in;
   } req_type_type;

   typedef struct packed {
      logic [2:0] status;
      logic [46:0] token_out;
      logic [31:0] payload_ref_out;
      logic usage_class_out;
      logic [6:0] active_count;
   } rsp_type;
endpackage

### rtl/ght_ram.sv
// Generic single-port RAM with registered read.
module ght_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write, and register the read of the old contents
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### rtl/generational_handle_table.sv
// Top level of the generational handle table.
//
//   channel | ports        | direction
//   req     | req_*        | in, valid/ready
//   rsp     | rsp_*        | out, valid/ready
//   csr     | csr_*        | in, write only
//
// Slot records live in a RAM with registered read; the shared slot update unit
// visits one slot at a time (read, then write back).
// Token operations visit their one slot in the steps accept, read, write and result.
// Allocate stops at the slot it takes, or walks every slot when the table is full.
// Expire by usage, reset all and the unused code visit every slot.
// After reset a clearing pass over every slot holds req_ready low; the request
// side is not ready again until the result is taken.
module generational_handle_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ght_pkg::req_type_type     req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ght_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [7:0]                csr_wdata
);
   import ght_pkg::*;
   `include "assert_macros.svh"

   logic format_ff;
   logic [7:0] tag_ff;
   fsm_type fsm_ff, fsm_in;
   req_type_type req_ff;
   rsp_type rsp_ff;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] live_ff;

   // effective tag and limit
   logic [7:0] eff_tag;
   logic [15:0] lim;
   always_comb begin
      eff_tag = format_ff ? tag_ff : {2'b0, tag_ff[5:0]};
      if (eff_tag == 8'd0) eff_tag = 8'd1;
      lim = format_ff ? GEN_LIMIT_WIDE : GEN_LIMIT_NARROW;
   end

   // token decode
   logic tok_ok;
   logic [15:0] tok_gen, tok_sl;
   always_comb begin
      logic [63:0] t;
      logic [6:0] mk;
      logic [7:0] tg;
      t = req_ff.token;
      if (!format_ff) begin
         mk = t[31:25]; tg = {2'b0, t[24:19]};
         tok_gen = {5'd0, t[18:8]}; tok_sl = {8'd0, t[7:0]};
      end else begin
         mk = t[46:40]; tg = t[39:32]; tok_gen = t[31:16]; tok_sl = t[15:0];
      end
      tok_ok = (t != 64'd0) && (format_ff || t[63:32] == 32'd0) && mk == MARKER
               && tg == eff_tag && tok_sl != 16'd0
               && tok_sl <= 16'(SLOT_COUNT) && tok_gen != 16'd0;
   end
   logic [SLOT_W-1:0] tok_slot;
   assign tok_slot = SLOT_W'(tok_sl - 16'd1);

   logic is_tok_op;
   assign is_tok_op = req_ff.req_type inside {OP_RESOLVE, OP_MARK, OP_CONSUME, OP_EXPIRE};

   // token operations visit the token slot, the others walk the scan index
   logic [SLOT_W-1:0] cur;
   assign cur = is_tok_op ? tok_slot : idx_ff;

   // slot RAM
   slot_type slot_q, slot_wd;
   logic slot_we;
   logic [SLOT_W-1:0] slot_addr;

   // shared slot unit: decide the new record of the visited slot
   slot_state_type cs, ns;
   logic [15:0] cg, ng;
   logic nu;
   logic take;
   logic [2:0] stat;
   always_comb begin
      cs = slot_q.st; cg = slot_q.gen; nu = slot_q.usage; ns = cs; ng = cg;
      take = 1'b0;
      stat = RS_OK;
      case (req_ff.req_type)
         OP_ALLOC: begin
            if (cs != ST_RET && cs != ST_ALLOC && cs != ST_DELIV) begin
               if ((cs == ST_CONS || cs == ST_EXP) && cg >= lim) begin
                  ns = ST_RET;
               end else begin
                  if (cs == ST_CONS || cs == ST_EXP) begin
                     ng = cg + 16'd1; ns = ST_FREE;
                  end
                  if (ng == 16'd0 || ng > lim) ns = ST_RET;
                  else begin
                     ns = ST_ALLOC; nu = req_ff.usage_class; take = 1'b1;
                  end
               end
            end
         end
         OP_RESOLVE, OP_MARK, OP_CONSUME, OP_EXPIRE: begin
            if (!tok_ok) stat = RS_UNKNOWN;
            else if (tok_gen != cg) stat = RS_STALE;
            else begin
               case (req_ff.req_type)
                  OP_RESOLVE: if (cs == ST_CONS) stat = RS_CONSUMED;
                     else if (cs != ST_ALLOC && cs != ST_DELIV) stat = RS_STALE;
                  OP_MARK: if (cs != ST_ALLOC) stat = RS_STALE;
                     else ns = ST_DELIV;
                  OP_CONSUME: if (cs == ST_CONS) stat = RS_CONSUMED;
                     else if (cs != ST_ALLOC && cs != ST_DELIV) stat = RS_STALE;
                     else ns = ST_CONS;
                  default: if (cs != ST_ALLOC && cs != ST_DELIV) stat = RS_STALE;
                     else ns = ST_EXP;
               endcase
            end
         end
         OP_EXPIRE_USAGE: begin
            if ((cs == ST_ALLOC || cs == ST_DELIV) && slot_q.usage == req_ff.usage_class)
               ns = ST_EXP;
         end
         OP_RESET_ALL: begin
            if (cs != ST_RET) begin
               if (cg >= lim) ns = ST_RET;
               else begin
                  ng = cg + 16'd1; ns = ST_FREE;
               end
            end
         end
         default: ;
      endcase
   end

   // liveness before and after the visit, for the running count
   logic live_old, live_new;
   assign live_old = cs == ST_ALLOC || cs == ST_DELIV;
   assign live_new = ns == ST_ALLOC || ns == ST_DELIV;

   // clear every record after reset, else write back the visited slot
   assign slot_we = fsm_ff == FSM_CLEAR || fsm_ff == FSM_WRITE;
   assign slot_addr = (fsm_ff == FSM_CLEAR) ? idx_ff : cur;
   always_comb begin
      if (fsm_ff == FSM_CLEAR) begin
         slot_wd.st = ST_FREE; slot_wd.gen = 16'd1; slot_wd.usage = 1'b0;
      end else begin
         slot_wd.st = ns; slot_wd.gen = ng; slot_wd.usage = nu;
      end
   end
   ght_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOT_COUNT)) u_slot (
      .clock(clock), .wr_en(slot_we), .addr(slot_addr),
      .wr_data(slot_wd), .rd_data(slot_q));

   // payload RAM
   logic ram_we;
   logic [SLOT_W-1:0] ram_addr;
   logic [31:0] ram_q;
   assign ram_we = fsm_ff == FSM_WRITE && take;
   assign ram_addr = cur;
   ght_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_pay (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(req_ff.payload_ref_in), .rd_data(ram_q));

   // the visit in progress is the last one of this item
   logic last;
   assign last = is_tok_op || take || idx_ff == SLOT_W'(SLOT_COUNT - 1);

   // sequencer
   always_comb begin
      fsm_in = fsm_ff; idx_in = idx_ff;
      case (fsm_ff)
         FSM_CLEAR: begin
            if (idx_ff == SLOT_W'(SLOT_COUNT - 1)) begin
               fsm_in = FSM_IDLE; idx_in = '0;
            end else idx_in = idx_ff + 1'b1;
         end
         FSM_IDLE: if (req_valid) begin
            fsm_in = FSM_READ; idx_in = '0;
         end
         FSM_READ: fsm_in = FSM_WRITE;
         FSM_WRITE: begin
            if (last) fsm_in = FSM_DONE;
            else begin
               fsm_in = FSM_READ; idx_in = idx_ff + 1'b1;
            end
         end
         FSM_DONE: if (rsp_ready) fsm_in = FSM_IDLE;
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_CLEAR; idx_ff <= '0;
      end else begin
         fsm_ff <= fsm_in; idx_ff <= idx_in;
      end
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= 1'b1; tag_ff <= 8'd1;
      end else if (csr_we) begin
         if (csr_index == REG_FORMAT) format_ff <= csr_wdata[0];
         else tag_ff <= csr_wdata;
      end
   end

   // live count and result datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         case (fsm_ff)
            FSM_IDLE: if (req_valid) begin
               req_ff <= req_data;
               rsp_ff <= '0;
            end
            FSM_WRITE: begin
               if (live_new && !live_old) live_ff <= live_ff + 1'b1;
               else if (live_old && !live_new) live_ff <= live_ff - 1'b1;
               if (is_tok_op) begin
                  rsp_ff.status <= stat;
                  if (req_ff.req_type == OP_RESOLVE && stat == RS_OK) begin
                     rsp_ff.payload_ref_out <= ram_q;
                     rsp_ff.usage_class_out <= slot_q.usage;
                  end
               end else if (take) begin
                  rsp_ff.token_out <= format_ff
                     ? {MARKER, eff_tag, ng, 16'(idx_ff) + 16'd1}
                     : {15'd0, MARKER, eff_tag[5:0], ng[10:0], 8'(idx_ff) + 8'd1};
               end else if (req_ff.req_type == OP_ALLOC
                            && idx_ff == SLOT_W'(SLOT_COUNT - 1)) begin
                  rsp_ff.status <= RS_FULL;
               end
            end
            default: ;
         endcase
      end
   end

   // handshakes and result
   assign req_ready = fsm_ff == FSM_IDLE;
   assign rsp_valid = fsm_ff == FSM_DONE;
   always_comb begin
      rsp_data = rsp_ff;
      rsp_data.active_count = live_ff;
   end

   `ASSERT_IMPLIES(a_excl, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, fsm_ff == FSM_READ)
   `ASSERT_IMPLIES(a_cnt, clock, reset, rsp_valid, live_ff <= 7'(SLOT_COUNT))
endmodule

### tb/sv/tb_top.sv
// Testbench for the generational handle table: directed and random operations checked
// against a predictor of the slot table.
module tb_top;
   import ght_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   // Predictor state
   logic fmt;
   logic [7:0] ctx;
   slot_state_type st_q [SLOT_COUNT];
   logic [15:0] gen_q [SLOT_COUNT];
   logic use_q [SLOT_COUNT];
   logic [31:0] pay_q [SLOT_COUNT];

   rsp_type pending_rsp [$];
   logic [46:0] issued [$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;

   generational_handle_table dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stall the receiver on its own pattern
   always @(posedge clock) begin
      if (cycles[9:7] == 3'd2) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // Check each result
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected item %h", $realtime, rsp_data);
            errors++;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (exp_r.status !== rsp_data.status)
               $display("%0t status exp %0d got %0d", $realtime, exp_r.status,
                        rsp_data.status);
            if (exp_r.token_out !== rsp_data.token_out)
               $display("%0t token exp %h got %h", $realtime, exp_r.token_out,
                        rsp_data.token_out);
            if (exp_r.payload_ref_out !== rsp_data.payload_ref_out)
               $display("%0t payload exp %h got %h", $realtime,
                        exp_r.payload_ref_out, rsp_data.payload_ref_out);
            if (exp_r.usage_class_out !== rsp_data.usage_class_out)
               $display("%0t usage exp %0d got %0d", $realtime,
                        exp_r.usage_class_out, rsp_data.usage_class_out);
            if (exp_r.active_count !== rsp_data.active_count)
               $display("%0t count exp %0d got %0d", $realtime, exp_r.active_count,
                        rsp_data.active_count);
            if (exp_r !== rsp_data) errors++;
         end
      end
   end

   function automatic logic [15:0] gen_limit();
      return fmt ? GEN_LIMIT_WIDE : GEN_LIMIT_NARROW;
   endfunction

   function automatic logic [7:0] eff_tag();
      logic [7:0] t;
      t = fmt ? ctx : {2'b00, ctx[5:0]};
      return (t == 0) ? 8'd1 : t;
   endfunction

   function automatic logic [46:0] build_token(int slot, logic [15:0] g);
      logic [15:0] s;
      logic [7:0] et;
      s = 16'(slot + 1);
      et = eff_tag();
      if (!fmt) return {15'd0, MARKER, et[5:0], g[10:0], s[7:0]};
      return {MARKER, et, g, s};
   endfunction

   function automatic logic is_live(int i);
      return st_q[i] == ST_ALLOC || st_q[i] == ST_DELIV;
   endfunction

   // Work out the result of one item and advance the slot table
   function automatic rsp_type predict_table(req_type_type r);
      rsp_type o;
      logic [63:0] tok;
      logic [6:0] mk;
      logic [7:0] tg;
      logic [15:0] g, sl;
      logic ok;
      int slot, cnt;
      o = '0;
      tok = r.token;
      case (op_type'(r.req_type))
         OP_ALLOC: begin
            o.status = RS_FULL;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (st_q[i] == ST_RET || is_live(i)) continue;
               if (st_q[i] == ST_CONS || st_q[i] == ST_EXP) begin
                  if (gen_q[i] >= gen_limit()) begin
                     st_q[i] = ST_RET;
                     continue;
                  end
                  gen_q[i] = gen_q[i] + 16'd1;
                  st_q[i] = ST_FREE;
               end
               if (gen_q[i] == 0 || gen_q[i] > gen_limit()) begin
                  st_q[i] = ST_RET;
                  continue;
               end
               o.status = RS_OK;
               o.token_out = build_token(i, gen_q[i]);
               pay_q[i] = r.payload_ref_in;
               use_q[i] = r.usage_class;
               st_q[i] = ST_ALLOC;
               break;
            end
         end
         OP_RESOLVE, OP_MARK, OP_CONSUME, OP_EXPIRE: begin
            if (!fmt) begin
               mk = tok[31:25]; tg = {2'b00, tok[24:19]};
               g = {5'd0, tok[18:8]}; sl = {8'd0, tok[7:0]};
            end else begin
               mk = tok[46:40]; tg = tok[39:32]; g = tok[31:16]; sl = tok[15:0];
            end
            ok = tok != 0 && !(!fmt && tok[63:32] != 0) && mk == MARKER &&
                 tg == eff_tag() && sl != 0 && sl <= SLOT_COUNT && g != 0;
            slot = sl - 1;
            if (!ok) o.status = RS_UNKNOWN;
            else if (g != gen_q[slot]) o.status = RS_STALE;
            else begin
               case (op_type'(r.req_type))
                  OP_RESOLVE: begin
                     if (st_q[slot] == ST_CONS) o.status = RS_CONSUMED;
                     else if (!is_live(slot)) o.status = RS_STALE;
                     else begin
                        o.payload_ref_out = pay_q[slot];
                        o.usage_class_out = use_q[slot];
                     end
                  end
                  OP_MARK: begin
                     if (st_q[slot] != ST_ALLOC) o.status = RS_STALE;
                     else st_q[slot] = ST_DELIV;
                  end
                  OP_CONSUME: begin
                     if (st_q[slot] == ST_CONS) o.status = RS_CONSUMED;
                     else if (!is_live(slot)) o.status = RS_STALE;
                     else st_q[slot] = ST_CONS;
                  end
                  default: begin
                     if (!is_live(slot)) o.status = RS_STALE;
                     else st_q[slot] = ST_EXP;
                  end
               endcase
            end
         end
         OP_EXPIRE_USAGE: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (is_live(i) && use_q[i] == r.usage_class) st_q[i] = ST_EXP;
         end
         OP_RESET_ALL: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (st_q[i] == ST_RET) continue;
               if (gen_q[i] >= gen_limit()) st_q[i] = ST_RET;
               else begin
                  gen_q[i] = gen_q[i] + 16'd1;
                  st_q[i] = ST_FREE;
               end
            end
         end
         default: ;
      endcase
      cnt = 0;
      for (int i = 0; i < SLOT_COUNT; i++) if (is_live(i)) cnt++;
      o.active_count = (cnt > 127) ? 7'd127 : cnt[6:0];
      return o;
   endfunction

   // Send one item, with bursts and gaps on the sender side
   task automatic send_item(input req_type_type r);
      rsp_type o;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      o = predict_table(r);
      pending_rsp.insert(pending_rsp.size(), o);
      if (r.req_type == OP_ALLOC && o.status == RS_OK) begin
         issued.insert(issued.size(), o.token_out);
         if (issued.size() > 32) void'(issued.pop_front());
      end
   endtask

   task automatic send_op(op_type op, logic [63:0] tok, logic u = 1'b0,
                          logic [31:0] p = 32'd0);
      req_type_type r;
      r.req_type = op;
      r.token = tok;
      r.usage_class = u;
      r.payload_ref_in = p;
      send_item(r);
   endtask

   // Hold the sender until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SLOT_COUNT + 10) @(posedge clock);
   endtask

   // Write one register while idle
   task automatic write_csr(logic idx, logic [7:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_FORMAT) fmt = val[0];
      else ctx = val;
      issued.delete();
   endtask

   function automatic logic [63:0] pick_token();
      logic [63:0] t;
      int k;
      k = $urandom_range(0, 9);
      if (issued.size() != 0 && k < 7) begin
         t = issued[$urandom_range(0, issued.size() - 1)];
         if (k == 6) t[$urandom_range(0, fmt ? 46 : 31)] ^= 1'b1;
         return t;
      end
      if (k == 7) return {$urandom, $urandom};
      t = build_token($urandom_range(0, SLOT_COUNT + 1) - 1, 16'($urandom_range(0, 3)));
      if (fmt && k == 8) t[63:47] = 17'({$urandom, $urandom});
      return t;
   endfunction

   // Extremes of the fields and the status codes other than full
   task automatic test_directed();
      logic [46:0] t0;
      send_op(OP_ALLOC, '0, 1'b1, 32'hffffffff);
      t0 = issued[$];
      send_op(OP_RESOLVE, {17'd0, t0});
      send_op(OP_RESOLVE, {17'h1ffff, t0});
      send_op(OP_RESOLVE, 64'd0);
      send_op(OP_RESOLVE, 64'hffffffffffffffff);
      send_op(OP_MARK, {17'd0, t0});
      send_op(OP_MARK, {17'd0, t0});
      send_op(OP_CONSUME, {17'd0, t0});
      send_op(OP_CONSUME, {17'd0, t0});
      send_op(OP_RESOLVE, {17'd0, t0});
      send_op(OP_EXPIRE, {17'd0, t0});
      send_op(OP_ALLOC, '0, 1'b0, 32'd0);
      send_op(OP_RESOLVE, {17'd0, t0});
      send_op(OP_RESOLVE, {17'd0, build_token(SLOT_COUNT, 16'd1)});
      send_op(OP_RESOLVE, {17'd0, build_token(0, 16'd0)});
      send_op(OP_EXPIRE, {17'd0, issued[$]});
      send_op(OP_ALLOC, '0, 1'b1, 32'h5a5a5a5a);
      send_op(OP_EXPIRE_USAGE, '0, 1'b0);
      send_op(OP_EXPIRE_USAGE, '0, 1'b1);
      send_op(OP_RESET_ALL, '0);
      send_op(OP_NONE, 64'hffffffffffffffff);
   endtask

   // Fill the table to full, then recycle it
   task automatic test_full();
      for (int i = 0; i < SLOT_COUNT + 2; i++)
         send_op(OP_ALLOC, '0, i[0], $urandom);
      send_op(OP_RESET_ALL, '0);
   endtask

   // Random operations; the token operations mostly use issued tokens
   task automatic test_random(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 30) send_op(OP_ALLOC, '0, 1'($urandom), $urandom);
         else if (k < 95)
            send_op(op_type'($urandom_range(OP_RESOLVE, OP_EXPIRE)), pick_token(),
                    1'($urandom), $urandom);
         else if (k < 97) send_op(OP_EXPIRE_USAGE, pick_token(), 1'($urandom), $urandom);
         else if (k < 98) send_op(OP_RESET_ALL, pick_token(), 1'($urandom), $urandom);
         else send_op(OP_NONE, pick_token(), 1'($urandom), $urandom);
      end
   endtask

   // Switch to narrow tokens and age every slot with repeated reset-all
   task automatic test_retire();
      write_csr(REG_FORMAT, 1'b0);
      for (int i = 0; i < 14; i++) send_op(OP_RESET_ALL, '0);
      drain();
   endtask

   initial begin
      fmt = 1'b1;
      ctx = 8'd1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         st_q[i] = ST_FREE;
         gen_q[i] = 16'd1;
         use_q[i] = 1'b0;
         pay_q[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full();
      test_random(200);
      write_csr(REG_TAG, 8'hff);
      test_random(250);
      test_retire();
      write_csr(REG_TAG, 8'h40);
      test_directed();
      test_random(250);
      write_csr(REG_TAG, 8'h00);
      test_random(200);
      write_csr(REG_FORMAT, 1'b1);
      test_random(150);
      test_full();

      drain();
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
